// ===== design/cmrh_pkg.sv =====
// Package: shared types, constants and the byte-wise CRC update for the marker hash block.
`timescale 1ns / 1ps
`default_nettype none
package cmrh_pkg;

    localparam logic [31:0] PolyLegacy = 32'hEDB88320;
    localparam logic [31:0] PolyCastagnoli = 32'h82F63B78;
    localparam logic [7:0] MarkByte = 8'h23;
    localparam int QueueDepth = 4;

    // One hashing command: optional CRC load, up to three bytes, optional result
    typedef struct packed {
        logic            load;
        logic [31:0]     load_val;
        logic [1:0]      nbytes;
        logic [2:0][7:0] bytes;
        logic            emit;
    } t_cmd;

    // Fold one byte into a reflected CRC; a fixed XOR network per polynomial
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                             input logic legacy);
        logic [31:0] poly;
        logic [31:0] c;
        poly = legacy ? PolyLegacy : PolyCastagnoli;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/cmrh_if.sv =====
// Interfaces: input byte channel and hash result channel.
`timescale 1ns / 1ps
`default_nettype none
interface cmrh_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] start_seed;
    logic        keep_marker;

    modport source (output valid, data_byte, last, start_seed, keep_marker, input ready);
    modport sink (input valid, data_byte, last, start_seed, keep_marker, output ready);
endinterface

interface cmrh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;

    modport source (output valid, hash, input ready);
    modport sink (input valid, hash, output ready);
endinterface
`default_nettype wire

// ===== design/cmrh_front.sv =====
// Front end: accepts bytes, tracks the lookahead window and turns markers into commands.
`timescale 1ns / 1ps
`default_nettype none
module cmrh_front
    import cmrh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cmrh_in_if.sink    i_in,
    output t_cmd       o_cmd,
    output logic       o_push,
    input  wire logic  i_full
);

    logic        r_in_string;
    logic        r_keep;
    logic [31:0] r_restart;
    logic [1:0]  r_pend;
    logic [7:0]  r_la0;
    logic [7:0]  r_la1;

    logic        c_new;
    logic        c_keep;
    logic [31:0] c_restart;
    logic [1:0]  c_pend;
    logic        c_mark;
    logic        c_hashed;
    logic        c_load;
    logic [1:0]  n_pend;
    logic [7:0]  n_la0;
    logic [7:0]  n_la1;
    logic        w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign o_push     = w_accept;

    // Classify the request against the window
    always_comb begin
        c_new     = !r_in_string;
        c_keep    = c_new ? i_in.keep_marker : r_keep;
        c_restart = c_new ? ~i_in.start_seed : r_restart;
        c_pend    = c_new ? 2'd0 : r_pend;
        c_mark    = (r_la0 == MarkByte) && (r_la1 == MarkByte) && (i_in.data_byte == MarkByte);
        c_load    = c_new;
        c_hashed  = 1'b0;
        n_pend    = c_pend;
        n_la0     = r_la0;
        n_la1     = r_la1;
        if (c_pend == 2'd2) begin
            if (c_mark) begin
                c_load = 1'b1;
            end
            if (c_mark && !c_keep) begin
                n_pend = 2'd0;
            end else begin
                c_hashed = 1'b1;
                n_la0    = r_la1;
                n_la1    = i_in.data_byte;
            end
        end else if (c_pend == 2'd0) begin
            n_la0  = i_in.data_byte;
            n_pend = 2'd1;
        end else begin
            n_la1  = i_in.data_byte;
            n_pend = 2'd2;
        end
    end

    // Build the command: oldest window byte first, then the flushed tail
    always_comb begin
        o_cmd.load     = c_load;
        o_cmd.load_val = c_restart;
        o_cmd.bytes[0] = c_hashed ? r_la0 : n_la0;
        o_cmd.bytes[1] = c_hashed ? n_la0 : n_la1;
        o_cmd.bytes[2] = n_la1;
        o_cmd.nbytes   = {1'b0, c_hashed} + (i_in.last ? n_pend : 2'd0);
        o_cmd.emit     = i_in.last;
    end

    // Advance string state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_keep      <= 1'b0;
            r_restart   <= '0;
            r_pend      <= 2'd0;
        end else if (w_accept) begin
            r_in_string <= !i_in.last;
            r_keep      <= c_keep;
            r_restart   <= c_restart;
            r_pend      <= i_in.last ? 2'd0 : n_pend;
        end
    end

    // Window bytes carry no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_la0 <= n_la0;
            r_la1 <= n_la1;
        end
    end

endmodule
`default_nettype wire

// ===== design/cmrh_queue.sv =====
// Command queue between the front end and the CRC engine.
`timescale 1ns / 1ps
`default_nettype none
module cmrh_queue
    import cmrh_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_cmd  i_wdata,
    input  wire logic  i_pop,
    output t_cmd       o_rdata,
    output logic       o_full,
    output logic       o_empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    t_cmd            r_mem [Depth];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(Depth));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== design/cmrh_back.sv =====
// Back end: folds command bytes into CRC, one per unstalled cycle; registers hash.
`timescale 1ns / 1ps
`default_nettype none
module cmrh_back
    import cmrh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_empty,
    output logic       o_pop,
    input  wire logic  i_legacy_poly,
    cmrh_out_if.source o_out
);

    logic [31:0] r_crc;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_hash;

    logic [31:0] c_in;
    logic [31:0] c_out;
    logic        c_final;
    logic        c_slot_free;
    logic        c_step;

    assign o_out.valid = r_out_valid;
    assign o_out.hash  = r_hash;

    // Pick the start value and fold the current byte
    always_comb begin
        c_in        = (r_idx == 2'd0 && i_cmd.load) ? i_cmd.load_val : r_crc;
        c_out       = (i_cmd.nbytes == 2'd0) ? c_in
                                             : crc_byte(c_in, i_cmd.bytes[r_idx], i_legacy_poly);
        c_final     = (i_cmd.nbytes == 2'd0) || (r_idx == i_cmd.nbytes - 2'd1);
        c_slot_free = !r_out_valid || o_out.ready;
        c_step      = !i_empty && (!c_final || !i_cmd.emit || c_slot_free);
        o_pop       = c_step && c_final;
    end

    // Hold CRC and byte index; drop output once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (c_step) begin
                r_crc <= c_out;
                r_idx <= c_final ? 2'd0 : r_idx + 2'd1;
            end
            if (o_pop && i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.emit) begin
            r_hash <= ~c_out;
        end
    end

endmodule
`default_nettype wire

// ===== design/crc32_marker_reset_hash.sv =====
// Top level: reflected CRC-32 string hash with "###" restart markers.
//
//  channel  dir  handshake          payload
//  i_in     in   valid / ready      data_byte, last, start_seed, keep_marker
//  o_out    out  valid / ready      hash
//  cfg      in   i_cfg_we           i_cfg_wdata (legacy_poly)
//
// One byte is accepted per cycle while the command queue has room.
// Each byte becomes one queue command; the CRC engine folds one byte per cycle while
// not stalled, so a last byte that flushes a full window gives it up to three bytes.
// Result appears in the cycle after its command completes, from an output register.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled output holds only the final step of its command; the queue absorbs the rest.
`timescale 1ns / 1ps
`default_nettype none
module crc32_marker_reset_hash
    import cmrh_pkg::*;
#(
    parameter int QDepth = QueueDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cmrh_in_if.sink    i_in,
    cmrh_out_if.source o_out,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata
);

    logic r_legacy_poly;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // Hold the polynomial select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legacy_poly <= 1'b0;
        end else if (i_cfg_we) begin
            r_legacy_poly <= i_cfg_wdata;
        end
    end

    cmrh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (w_push_cmd),
        .o_push  (w_push),
        .i_full  (w_full)
    );

    cmrh_queue #(
        .Depth (QDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_cmd),
        .i_pop   (w_pop),
        .o_rdata (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    cmrh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_legacy_poly (r_legacy_poly),
        .o_out         (o_out)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into full queue");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from empty queue");

    // A result waiting at the output keeps its value
    a_hash_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.hash)))
        else $error("pending hash changed");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire
